@@ sv/omu_pkg.sv @@
`default_nettype none
package omu_pkg;

  localparam int W_ROW   = 16;
  localparam int W_OMEGA = 32;
  localparam int W_TS    = 24;
  localparam logic [W_TS-1:0] TS_RESET = 24'd279620;

  // omega * time_step, Q17.40, and its rounding to Q2.14
  localparam int W_PROD = W_OMEGA + W_TS + 1;
  localparam int RND_SH = 26;
  localparam int W_WQ   = W_PROD - RND_SH;
  localparam logic signed [W_PROD-1:0] RND_HALF = W_PROD'(64'sd1 <<< (RND_SH - 1));
  localparam logic signed [W_WQ-1:0] W_MAX = W_WQ'(32767);
  localparam logic signed [W_WQ-1:0] W_MIN = -W_WQ'(32768);

  localparam int W_XP   = 2 * W_ROW;     // cross product terms
  localparam int FRAC   = 14;
  localparam int W_V    = 34;            // v in Q6.28
  localparam int W_MAG  = 32;
  localparam int W_SH   = 5;
  localparam int W_NM   = 30;            // normalized magnitude, msb of max at bit 29
  localparam logic [W_SH-1:0] NORM_MSB = 5'd29;
  localparam int W_SQ   = 2 * W_NM;
  localparam int W_SUM  = W_SQ + 2;
  localparam int W_LEN  = W_SUM / 2;
  localparam int W_SRM  = W_LEN + 1;     // sqrt partial remainder

  localparam int W_Q    = 15;
  localparam int W_DEN  = W_LEN + 1;
  localparam int W_DRM  = W_NM + W_Q + 2;
  localparam logic [W_Q-1:0] ONE_Q14 = 15'd16384;

  localparam int SCALE_STAGES = 2;
  localparam int FRONT_STAGES = 6;
  localparam int SQRT_STAGES  = W_LEN;
  localparam int DIV_STAGES   = W_Q;
  localparam int NORM_DLY     = 2 + SQRT_STAGES;
  localparam int PIPE_DEPTH   = SCALE_STAGES + FRONT_STAGES + SQRT_STAGES + DIV_STAGES;

  typedef struct packed {
    logic [2:0][W_NM-1:0] nm;
    logic [2:0]           neg;
    logic                 zero;
  } lane_dly_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } lane_side_t;

  function automatic logic [W_SH-1:0] msb_pos(input logic [W_MAG-1:0] x);
    logic [W_SH-1:0] p;
    p = '0;
    for (int i = 0; i < W_MAG; i++) begin
      if (x[i]) p = W_SH'(i);
    end
    return p;
  endfunction

endpackage
`default_nettype wire

@@ sv/omu_scale.sv @@
`default_nettype none
module omu_scale (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [omu_pkg::W_TS-1:0]             ts,
  input  logic signed [omu_pkg::W_OMEGA-1:0]   omega [3],
  output logic signed [omu_pkg::W_ROW-1:0]     w [3]
);

  logic signed [omu_pkg::W_PROD-1:0] prod_r [3];
  logic signed [omu_pkg::W_ROW-1:0]  w_r [3];
  logic signed [omu_pkg::W_PROD-1:0] rnd [3];
  logic signed [omu_pkg::W_WQ-1:0]   q [3];
  logic signed [omu_pkg::W_ROW-1:0]  w_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = prod_r[i] + omu_pkg::RND_HALF;
      q[i]   = rnd[i][omu_pkg::W_PROD-1:omu_pkg::RND_SH];
      if (q[i] > omu_pkg::W_MAX) begin
        w_nxt[i] = omu_pkg::W_ROW'(omu_pkg::W_MAX);
      end else if (q[i] < omu_pkg::W_MIN) begin
        w_nxt[i] = omu_pkg::W_ROW'(omu_pkg::W_MIN);
      end else begin
        w_nxt[i] = q[i][omu_pkg::W_ROW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= omega[i] * $signed({1'b0, ts});
        w_r[i]    <= w_nxt[i];
      end
    end
  end

  assign w = w_r;

endmodule
`default_nettype wire

@@ sv/omu_isqrt.sv @@
`default_nettype none
module omu_isqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [omu_pkg::W_SUM-1:0]    x,
  output logic [omu_pkg::W_LEN-1:0]    root
);

  localparam int N = omu_pkg::SQRT_STAGES;

  logic [omu_pkg::W_SRM-1:0] rem_r  [N];
  logic [omu_pkg::W_LEN-1:0] root_r [N];
  logic [omu_pkg::W_SUM-1:0] x_r    [N];

  logic [omu_pkg::W_SRM-1:0] st_rem  [N+1];
  logic [omu_pkg::W_LEN-1:0] st_root [N+1];
  logic [omu_pkg::W_SUM-1:0] st_x    [N+1];

  assign st_rem[0]  = '0;
  assign st_root[0] = '0;
  assign st_x[0]    = x;

  for (genvar k = 0; k < N; k++) begin : g_st
    logic [omu_pkg::W_SRM+1:0] cur;
    logic [omu_pkg::W_SRM+1:0] trial;
    logic                      ge;

    // one result bit per stage: bring down two bits, try root*4+1
    always_comb begin
      cur   = {st_rem[k], st_x[k][omu_pkg::W_SUM-1 -: 2]};
      trial = {1'b0, st_root[k], 2'b01};
      ge    = cur >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? omu_pkg::W_SRM'(cur - trial) : omu_pkg::W_SRM'(cur);
        root_r[k] <= {st_root[k][omu_pkg::W_LEN-2:0], ge};
        x_r[k]    <= st_x[k] << 2;
      end
    end

    assign st_rem[k+1]  = rem_r[k];
    assign st_root[k+1] = root_r[k];
    assign st_x[k+1]    = x_r[k];
  end

  assign root = st_root[N];

endmodule
`default_nettype wire

@@ sv/omu_div.sv @@
`default_nettype none
module omu_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [omu_pkg::W_DRM-1:0]   num,
  input  logic [omu_pkg::W_DEN-1:0]   den,
  output logic [omu_pkg::W_Q-1:0]     quo
);

  localparam int N = omu_pkg::DIV_STAGES;

  logic [omu_pkg::W_DRM-1:0] rem_r [N];
  logic [omu_pkg::W_DEN-1:0] den_r [N];
  logic [omu_pkg::W_Q-1:0]   q_r   [N];

  logic [omu_pkg::W_DRM-1:0] st_rem [N+1];
  logic [omu_pkg::W_DEN-1:0] st_den [N+1];
  logic [omu_pkg::W_Q-1:0]   st_q   [N+1];

  assign st_rem[0] = num;
  assign st_den[0] = den;
  assign st_q[0]   = '0;

  // restoring division, quotient msb first
  for (genvar j = 0; j < N; j++) begin : g_st
    logic [omu_pkg::W_DRM-1:0] dsh;
    logic                      ge;

    always_comb begin
      dsh = omu_pkg::W_DRM'(st_den[j]) << (N - 1 - j);
      ge  = st_rem[j] >= dsh;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? st_rem[j] - dsh : st_rem[j];
        den_r[j] <= st_den[j];
        q_r[j]   <= {st_q[j][omu_pkg::W_Q-2:0], ge};
      end
    end

    assign st_rem[j+1] = rem_r[j];
    assign st_den[j+1] = den_r[j];
    assign st_q[j+1]   = q_r[j];
  end

  assign quo = st_q[N];

endmodule
`default_nettype wire

@@ sv/omu_lane.sv @@
`default_nettype none
module omu_lane (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [omu_pkg::W_ROW-1:0] r [3],
  input  logic signed [omu_pkg::W_ROW-1:0] w [3],
  output logic signed [omu_pkg::W_ROW-1:0] n [3]
);

  logic signed [omu_pkg::W_XP-1:0]  pa_r [3];
  logic signed [omu_pkg::W_XP-1:0]  pb_r [3];
  logic signed [omu_pkg::W_ROW-1:0] rs_r [3];
  logic signed [omu_pkg::W_V-1:0]   v_r [3];
  logic [omu_pkg::W_MAG-1:0]        mag_r [3];
  logic [2:0]                       neg_r;
  logic [omu_pkg::W_MAG-1:0]        mx_r;
  omu_pkg::lane_dly_t               s6_r;
  logic [omu_pkg::W_SQ-1:0]         sq_r [3];
  logic [omu_pkg::W_SUM-1:0]        sum_r;
  omu_pkg::lane_dly_t               dly_r [omu_pkg::NORM_DLY];
  omu_pkg::lane_side_t              side_r [omu_pkg::DIV_STAGES];

  logic [omu_pkg::W_MAG-1:0]        mag_nxt [3];
  logic [omu_pkg::W_MAG-1:0]        mx_nxt;
  logic signed [omu_pkg::W_V-1:0]   vneg [3];
  logic [omu_pkg::W_SH-1:0]         sh;
  logic [omu_pkg::W_SUM-1:0]        wide [3];
  omu_pkg::lane_dly_t               s6_nxt;
  logic [omu_pkg::W_LEN-1:0]        len;
  logic [omu_pkg::W_Q-1:0]          quo [3];
  logic [omu_pkg::W_Q-1:0]          qc [3];

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r[0] <= w[1] * r[2];
      pb_r[0] <= w[2] * r[1];
      pa_r[1] <= w[2] * r[0];
      pb_r[1] <= w[0] * r[2];
      pa_r[2] <= w[0] * r[1];
      pb_r[2] <= w[1] * r[0];
      for (int i = 0; i < 3; i++) begin
        rs_r[i] <= r[i];
        v_r[i]  <= (omu_pkg::W_V'(rs_r[i]) <<< omu_pkg::FRAC)
                   + omu_pkg::W_V'(pa_r[i]) - omu_pkg::W_V'(pb_r[i]);
        mag_r[i] <= mag_nxt[i];
        sq_r[i]  <= omu_pkg::W_SQ'(s6_r.nm[i]) * omu_pkg::W_SQ'(s6_r.nm[i]);
      end
      neg_r <= {v_r[2][omu_pkg::W_V-1], v_r[1][omu_pkg::W_V-1], v_r[0][omu_pkg::W_V-1]};
      mx_r  <= mx_nxt;
      s6_r  <= s6_nxt;
      sum_r <= omu_pkg::W_SUM'(sq_r[0]) + omu_pkg::W_SUM'(sq_r[1])
               + omu_pkg::W_SUM'(sq_r[2]);
      dly_r[0] <= s6_r;
      for (int i = 1; i < omu_pkg::NORM_DLY; i++) dly_r[i] <= dly_r[i-1];
      side_r[0] <= '{neg: dly_r[omu_pkg::NORM_DLY-1].neg,
                     zero: dly_r[omu_pkg::NORM_DLY-1].zero};
      for (int i = 1; i < omu_pkg::DIV_STAGES; i++) side_r[i] <= side_r[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vneg[i]    = -v_r[i];
      mag_nxt[i] = v_r[i][omu_pkg::W_V-1] ? vneg[i][omu_pkg::W_MAG-1:0]
                                           : v_r[i][omu_pkg::W_MAG-1:0];
    end
    mx_nxt = mag_nxt[0];
    if (mag_nxt[1] > mx_nxt) mx_nxt = mag_nxt[1];
    if (mag_nxt[2] > mx_nxt) mx_nxt = mag_nxt[2];
  end

  // common shift that puts the largest magnitude at bit 29, right shifts truncate
  always_comb begin
    sh = omu_pkg::msb_pos(mx_r);
    s6_nxt.neg  = neg_r;
    s6_nxt.zero = mx_r == '0;
    for (int i = 0; i < 3; i++) begin
      wide[i] = omu_pkg::W_SUM'(mag_r[i]) << (omu_pkg::NORM_MSB - sh);
      if (sh > omu_pkg::NORM_MSB) begin
        s6_nxt.nm[i] = omu_pkg::W_NM'(mag_r[i] >> (sh - omu_pkg::NORM_MSB));
      end else begin
        s6_nxt.nm[i] = wide[i][omu_pkg::W_NM-1:0];
      end
    end
  end

  omu_isqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .x    (sum_r),
    .root (len)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    logic [omu_pkg::W_DRM-1:0] num;
    assign num = (omu_pkg::W_DRM'(dly_r[omu_pkg::NORM_DLY-1].nm[i]) << (omu_pkg::W_Q))
                 + omu_pkg::W_DRM'(len);

    omu_div u_div (
      .clk (clk),
      .en  (en),
      .num (num),
      .den ({len, 1'b0}),
      .quo (quo[i])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (quo[i] > omu_pkg::ONE_Q14) ? omu_pkg::ONE_Q14 : quo[i];
      if (side_r[omu_pkg::DIV_STAGES-1].zero) begin
        n[i] = '0;
      end else if (side_r[omu_pkg::DIV_STAGES-1].neg[i]) begin
        n[i] = -$signed({1'b0, qc[i]});
      end else begin
        n[i] = $signed({1'b0, qc[i]});
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/orientation_matrix_update.sv @@
// results on out_n*, one request per cycle sustained while the output is not blocked
// most of the depth comes from the 31-stage square root and 15-stage dividers in each row lane
// three row lanes run side by side; the output register merges them into one result
// a request is taken while a result waits as long as the last pipeline stage is empty
// reset (rst_n low, synchronous) empties the pipeline and sets time_step to 279620
`default_nettype none
module orientation_matrix_update (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [omu_pkg::W_TS-1:0]          cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [omu_pkg::W_ROW-1:0]  in_r0x,
  input  logic signed [omu_pkg::W_ROW-1:0]  in_r0y,
  input  logic signed [omu_pkg::W_ROW-1:0]  in_r0z,
  input  logic signed [omu_pkg::W_ROW-1:0]  in_r1x,
  input  logic signed [omu_pkg::W_ROW-1:0]  in_r1y,
  input  logic signed [omu_pkg::W_ROW-1:0]  in_r1z,
  input  logic signed [omu_pkg::W_ROW-1:0]  in_r2x,
  input  logic signed [omu_pkg::W_ROW-1:0]  in_r2y,
  input  logic signed [omu_pkg::W_ROW-1:0]  in_r2z,
  input  logic signed [omu_pkg::W_OMEGA-1:0] in_omega_x,
  input  logic signed [omu_pkg::W_OMEGA-1:0] in_omega_y,
  input  logic signed [omu_pkg::W_OMEGA-1:0] in_omega_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [omu_pkg::W_ROW-1:0]  out_n0x,
  output logic signed [omu_pkg::W_ROW-1:0]  out_n0y,
  output logic signed [omu_pkg::W_ROW-1:0]  out_n0z,
  output logic signed [omu_pkg::W_ROW-1:0]  out_n1x,
  output logic signed [omu_pkg::W_ROW-1:0]  out_n1y,
  output logic signed [omu_pkg::W_ROW-1:0]  out_n1z,
  output logic signed [omu_pkg::W_ROW-1:0]  out_n2x,
  output logic signed [omu_pkg::W_ROW-1:0]  out_n2y,
  output logic signed [omu_pkg::W_ROW-1:0]  out_n2z
);

  localparam int D = omu_pkg::PIPE_DEPTH;

  logic [omu_pkg::W_TS-1:0]         ts_r;
  logic [D-1:0]                     vld_r;
  logic                             out_valid_r;
  logic signed [omu_pkg::W_ROW-1:0] row1_r [3][3];
  logic signed [omu_pkg::W_ROW-1:0] row2_r [3][3];
  logic signed [omu_pkg::W_ROW-1:0] res_r  [3][3];

  logic                             en;
  logic signed [omu_pkg::W_OMEGA-1:0] omega [3];
  logic signed [omu_pkg::W_ROW-1:0] w [3];
  logic signed [omu_pkg::W_ROW-1:0] lane_n [3][3];

  // stall only when the last stage holds a result and the output is blocked
  assign en       = !(out_valid_r && !out_ready && vld_r[D-1]);
  assign in_ready = en;

  assign omega[0] = in_omega_x;
  assign omega[1] = in_omega_y;
  assign omega[2] = in_omega_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r        <= omu_pkg::TS_RESET;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) ts_r <= cfg_wdata;
      if (en) vld_r <= {vld_r[D-2:0], in_valid};
      if (en && vld_r[D-1]) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row1_r[0] <= '{in_r0x, in_r0y, in_r0z};
      row1_r[1] <= '{in_r1x, in_r1y, in_r1z};
      row1_r[2] <= '{in_r2x, in_r2y, in_r2z};
      row2_r    <= row1_r;
      if (vld_r[D-1]) res_r <= lane_n;
    end
  end

  omu_scale u_scale (
    .clk   (clk),
    .en    (en),
    .ts    (ts_r),
    .omega (omega),
    .w     (w)
  );

  for (genvar l = 0; l < 3; l++) begin : g_lane
    omu_lane u_lane (
      .clk (clk),
      .en  (en),
      .r   (row2_r[l]),
      .w   (w),
      .n   (lane_n[l])
    );
  end

  assign out_valid = out_valid_r;
  assign out_n0x   = res_r[0][0];
  assign out_n0y   = res_r[0][1];
  assign out_n0z   = res_r[0][2];
  assign out_n1x   = res_r[1][0];
  assign out_n1y   = res_r[1][1];
  assign out_n1z   = res_r[1][2];
  assign out_n2x   = res_r[2][0];
  assign out_n2y   = res_r[2][1];
  assign out_n2z   = res_r[2][2];

endmodule
`default_nettype wire
